FILE: rtl/packed_key_value_record_store_assert.svh
// assertion macros for the packed key/value record store
// no dependencies; included by the modules that check their own logic
`ifndef PACKED_KEY_VALUE_RECORD_STORE_ASSERT_SVH
`define PACKED_KEY_VALUE_RECORD_STORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PKVRS_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define PKVRS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define PKVRS_ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define PKVRS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/pkvrs_pkg.sv
// shared types and codes of the packed key/value record store
// no dependencies
package pkvrs_pkg;

	typedef enum logic [1:0] {
		FUNC_GET = 2'd0,
		FUNC_SET = 2'd1,
		FUNC_DEL = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOTFND = 2'd1,
		STAT_NOSPC  = 2'd2,
		STAT_RSVD   = 2'd3
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_CHK    = 11'b000_0000_0010,
		ST_HRD    = 11'b000_0000_0100,
		ST_EVAL   = 11'b000_0000_1000,
		ST_COPY   = 11'b000_0001_0000,
		ST_HWR    = 11'b000_0010_0000,
		ST_SBYTE  = 11'b000_0100_0000,
		ST_COMMIT = 11'b000_1000_0000,
		ST_GRD    = 11'b001_0000_0000,
		ST_GLD    = 11'b010_0000_0000,
		ST_OUT    = 11'b100_0000_0000
	} state_t;

	localparam int unsigned HDR_BYTES = 4;
	localparam int unsigned XW = 18;

endpackage

FILE: rtl/packed_key_value_record_store.sv
// packed key/value record store: sequencer, byte store and result register
// depends on pkvrs_pkg and packed_key_value_record_store_assert.svh
//
// channel  | handshake              | payload
// req      | req_valid / req_ready  | func key occurrence value_length value_byte
//          |                        | last_byte read_limit
// rsp      | rsp_valid / rsp_ready  | status data_byte data_valid stored_length
//          |                        | last_result
//
// one item at a time; req_ready is high only while the sequencer is idle
// get/delete: walks the record headers one by one; delete then compacts the store
// set first item: header walk and compaction as above plus 4 header writes
// set later items: one byte each while room is left; the last item also commits the length
// get returns one byte per response; the next is read only after rsp_ready takes it
// reset clears only control state; store contents are undefined until written
`include "packed_key_value_record_store_assert.svh"
module packed_key_value_record_store #(
	parameter int unsigned CAPACITY = 8192,
	parameter int unsigned MAX_READ = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  func,
	input  logic [15:0] key,
	input  logic [10:0] occurrence,
	input  logic [12:0] value_length,
	input  logic [7:0]  value_byte,
	input  logic        last_byte,
	input  logic [6:0]  read_limit,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic [12:0] stored_length,
	output logic        last_result
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned UW = AW + 1;
	localparam int unsigned XW = pkvrs_pkg::XW;

	pkvrs_pkg::state_t st_q;

	// latched request
	pkvrs_pkg::func_t func_q;
	logic [15:0] key_q;
	logic [10:0] occ_q;
	logic [12:0] vlen_q;
	logic [7:0]  vbyte_q;
	logic        last_q;
	logic [6:0]  limit_q;

	// store state
	logic [UW-1:0] used_q, wp_q;
	logic          sip_q, sacc_q;
	logic [12:0]   set_len_q;

	// walk and copy state
	logic [UW-1:0] i_q, cnt_q, pos_q, src_q, dst_q, rem_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;
	logic [2:0]    hc_q;
	logic [31:0]   hdr_q;
	logic [6:0]    k_q, n_q;

	// result register
	pkvrs_pkg::status_t status_q;
	logic [7:0]  data_byte_q;
	logic        data_valid_q;
	logic [12:0] stored_length_q;
	logic        last_result_q;

	// byte store
	logic [7:0]    store_q [CAPACITY];
	logic [7:0]    rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0]    mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_wa] <= mem_wd;
		rdata_q <= store_q[mem_ra];
	end

	// header and walk arithmetic
	logic [15:0]   hkey, hlen;
	logic [XW-1:0] blk_full, avail, blk, nxt, got, fit_need;
	logic [6:0]    lim, nget;
	logic          byte_room;

	always_comb begin
		hkey      = hdr_q[15:0];
		hlen      = hdr_q[31:16];
		blk_full  = XW'(pkvrs_pkg::HDR_BYTES) + XW'(hlen);
		avail     = XW'(used_q) - XW'(i_q);
		blk       = (blk_full > avail) ? avail : blk_full;
		nxt       = XW'(i_q) + blk;
		got       = XW'(wp_q) - XW'(used_q) - XW'(pkvrs_pkg::HDR_BYTES);
		fit_need  = XW'(used_q) + XW'(pkvrs_pkg::HDR_BYTES) + XW'(vlen_q);
		lim       = (XW'(limit_q) > XW'(MAX_READ)) ? 7'(MAX_READ) : limit_q;
		nget      = (XW'(hlen) < XW'(lim)) ? hlen[6:0] : lim;
		byte_room = sacc_q && (got < XW'(set_len_q));
	end

	// store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_ra = '0;
		unique case (st_q)
			pkvrs_pkg::ST_HRD:
				mem_ra = AW'(XW'(i_q) + XW'(hc_q));
			pkvrs_pkg::ST_COPY: begin
				mem_ra = src_q[AW-1:0];
				mem_we = pend_q;
				mem_wa = pend_addr_q;
				mem_wd = rdata_q;
			end
			pkvrs_pkg::ST_HWR: begin
				mem_we = 1'b1;
				mem_wa = AW'(XW'(used_q) + XW'(hc_q));
				unique case (hc_q[1:0])
					2'd0: mem_wd = key_q[7:0];
					2'd1: mem_wd = key_q[15:8];
					2'd2: mem_wd = vlen_q[7:0];
					default: mem_wd = {3'b000, vlen_q[12:8]};
				endcase
			end
			pkvrs_pkg::ST_SBYTE: begin
				mem_we = byte_room;
				mem_wa = wp_q[AW-1:0];
				mem_wd = vbyte_q;
			end
			pkvrs_pkg::ST_COMMIT: begin
				mem_we = 1'b1;
				mem_wa = AW'(XW'(used_q) + XW'(2) + XW'(hc_q));
				mem_wd = hc_q[0] ? got[15:8] : got[7:0];
			end
			pkvrs_pkg::ST_GRD:
				mem_ra = AW'(XW'(pos_q) + XW'(pkvrs_pkg::HDR_BYTES) + XW'(k_q));
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= pkvrs_pkg::ST_IDLE;
			used_q <= '0;
			wp_q   <= '0;
			sip_q  <= 1'b0;
			sacc_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			unique case (st_q)
				pkvrs_pkg::ST_IDLE: begin
					if (req_valid) begin
						func_q  <= pkvrs_pkg::func_t'(func);
						key_q   <= key;
						occ_q   <= occurrence;
						vlen_q  <= value_length;
						vbyte_q <= value_byte;
						last_q  <= last_byte;
						limit_q <= read_limit;
						i_q     <= '0;
						cnt_q   <= '0;
						unique case (pkvrs_pkg::func_t'(func))
							pkvrs_pkg::FUNC_GET, pkvrs_pkg::FUNC_DEL: begin
								sip_q  <= 1'b0;
								sacc_q <= 1'b0;
								wp_q   <= used_q;
								st_q   <= pkvrs_pkg::ST_CHK;
							end
							pkvrs_pkg::FUNC_SET:
								st_q <= sip_q ? pkvrs_pkg::ST_SBYTE : pkvrs_pkg::ST_CHK;
							default:
								st_q <= pkvrs_pkg::ST_IDLE;
						endcase
					end
				end
				pkvrs_pkg::ST_CHK: begin
					hc_q <= '0;
					if (XW'(i_q) + XW'(pkvrs_pkg::HDR_BYTES) <= XW'(used_q)) begin
						st_q <= pkvrs_pkg::ST_HRD;
					end else if (func_q == pkvrs_pkg::FUNC_SET) begin
						sip_q     <= 1'b1;
						set_len_q <= vlen_q;
						if (fit_need <= XW'(CAPACITY)) begin
							st_q <= pkvrs_pkg::ST_HWR;
						end else begin
							sacc_q <= 1'b0;
							wp_q   <= used_q;
							st_q   <= pkvrs_pkg::ST_SBYTE;
						end
					end else begin
						status_q        <= pkvrs_pkg::STAT_NOTFND;
						data_byte_q     <= '0;
						data_valid_q    <= 1'b0;
						stored_length_q <= '0;
						last_result_q   <= 1'b1;
						st_q            <= pkvrs_pkg::ST_OUT;
					end
				end
				pkvrs_pkg::ST_HRD: begin
					// four header bytes, registered read data arriving the cycle after its address
					if (hc_q != 3'd0)
						hdr_q <= {rdata_q, hdr_q[31:8]};
					hc_q <= hc_q + 3'd1;
					if (hc_q == 3'd4)
						st_q <= pkvrs_pkg::ST_EVAL;
				end
				pkvrs_pkg::ST_EVAL: begin
					if (func_q == pkvrs_pkg::FUNC_SET) begin
						if (hkey == key_q) begin
							used_q <= UW'(XW'(used_q) - blk);
							src_q  <= UW'(nxt);
							dst_q  <= i_q;
							rem_q  <= UW'(XW'(used_q) - nxt);
							st_q   <= pkvrs_pkg::ST_COPY;
						end else begin
							i_q  <= UW'(nxt);
							st_q <= pkvrs_pkg::ST_CHK;
						end
					end else if (hkey == key_q && XW'(cnt_q) == XW'(occ_q)) begin
						pos_q           <= i_q;
						status_q        <= pkvrs_pkg::STAT_OK;
						data_byte_q     <= '0;
						data_valid_q    <= 1'b0;
						stored_length_q <= hlen[12:0];
						last_result_q   <= 1'b1;
						if (func_q == pkvrs_pkg::FUNC_DEL) begin
							used_q <= UW'(XW'(used_q) - blk);
							wp_q   <= UW'(XW'(used_q) - blk);
							src_q  <= UW'(nxt);
							dst_q  <= i_q;
							rem_q  <= UW'(XW'(used_q) - nxt);
							st_q   <= pkvrs_pkg::ST_COPY;
						end else begin
							n_q  <= nget;
							k_q  <= '0;
							st_q <= (nget == 7'd0) ? pkvrs_pkg::ST_OUT : pkvrs_pkg::ST_GRD;
						end
					end else begin
						if (hkey == key_q)
							cnt_q <= cnt_q + UW'(1);
						i_q  <= UW'(nxt);
						st_q <= pkvrs_pkg::ST_CHK;
					end
				end
				pkvrs_pkg::ST_COPY: begin
					// compaction: read ahead, write in the following cycle
					if (rem_q != '0) begin
						src_q       <= src_q + UW'(1);
						dst_q       <= dst_q + UW'(1);
						rem_q       <= rem_q - UW'(1);
						pend_q      <= 1'b1;
						pend_addr_q <= dst_q[AW-1:0];
					end else begin
						st_q <= (func_q == pkvrs_pkg::FUNC_SET) ? pkvrs_pkg::ST_CHK
						                                         : pkvrs_pkg::ST_OUT;
					end
				end
				pkvrs_pkg::ST_HWR: begin
					hc_q <= hc_q + 3'd1;
					if (hc_q == 3'd3) begin
						sacc_q <= 1'b1;
						wp_q   <= UW'(XW'(used_q) + XW'(pkvrs_pkg::HDR_BYTES));
						st_q   <= pkvrs_pkg::ST_SBYTE;
					end
				end
				pkvrs_pkg::ST_SBYTE: begin
					if (byte_room)
						wp_q <= wp_q + UW'(1);
					hc_q <= '0;
					if (last_q) begin
						sip_q <= 1'b0;
						if (sacc_q) begin
							st_q <= pkvrs_pkg::ST_COMMIT;
						end else begin
							status_q        <= pkvrs_pkg::STAT_NOSPC;
							data_byte_q     <= '0;
							data_valid_q    <= 1'b0;
							stored_length_q <= '0;
							last_result_q   <= 1'b1;
							st_q            <= pkvrs_pkg::ST_OUT;
						end
					end else begin
						st_q <= pkvrs_pkg::ST_IDLE;
					end
				end
				pkvrs_pkg::ST_COMMIT: begin
					hc_q <= hc_q + 3'd1;
					if (hc_q == 3'd1) begin
						used_q          <= wp_q;
						sacc_q          <= 1'b0;
						status_q        <= pkvrs_pkg::STAT_OK;
						data_byte_q     <= '0;
						data_valid_q    <= 1'b0;
						stored_length_q <= got[12:0];
						last_result_q   <= 1'b1;
						st_q            <= pkvrs_pkg::ST_OUT;
					end
				end
				pkvrs_pkg::ST_GRD:
					st_q <= pkvrs_pkg::ST_GLD;
				pkvrs_pkg::ST_GLD: begin
					status_q        <= pkvrs_pkg::STAT_OK;
					data_byte_q     <= rdata_q;
					data_valid_q    <= 1'b1;
					stored_length_q <= hlen[12:0];
					last_result_q   <= (k_q + 7'd1 == n_q);
					k_q             <= k_q + 7'd1;
					st_q            <= pkvrs_pkg::ST_OUT;
				end
				pkvrs_pkg::ST_OUT: begin
					if (rsp_ready)
						st_q <= (data_valid_q && !last_result_q) ? pkvrs_pkg::ST_GRD
						                                         : pkvrs_pkg::ST_IDLE;
				end
				default:
					st_q <= pkvrs_pkg::ST_IDLE;
			endcase
		end
	end

	// ports
	assign req_ready     = (st_q == pkvrs_pkg::ST_IDLE);
	assign rsp_valid     = (st_q == pkvrs_pkg::ST_OUT);
	assign status        = status_q;
	assign data_byte     = data_byte_q;
	assign data_valid    = data_valid_q;
	assign stored_length = stored_length_q;
	assign last_result   = last_result_q;

	// checks
	`PKVRS_ASSERT_IMPL(a_used_cap, clk, arst_n, 1'b1, XW'(used_q) <= XW'(CAPACITY))
	`PKVRS_ASSERT_IMPL(a_acc_in_set, clk, arst_n, sacc_q && !sip_q, st_q == pkvrs_pkg::ST_COMMIT)
	`PKVRS_ASSERT_IMPL(a_one_at_a_time, clk, arst_n, rsp_valid, !req_ready)
	`PKVRS_ASSERT_NEXT(a_set_wp, clk, arst_n, sacc_q && sip_q, XW'(wp_q) <= XW'(CAPACITY))

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the packed key/value record store
// depends on pkvrs_pkg and the packed_key_value_record_store rtl
`timescale 1ns / 1ps
module testbench;

	localparam int unsigned STORE_BYTES = 8192;
	localparam int unsigned READ_MAX = 64;
	localparam int unsigned STALL_LIMIT = 200000;

	typedef struct {
		pkvrs_pkg::func_t op;
		logic [15:0] key;
		logic [10:0] occ;
		logic [12:0] vlen;
		logic [7:0]  vbyte;
		logic        lastb;
		logic [6:0]  limit;
	} request_t;

	typedef struct {
		pkvrs_pkg::status_t st;
		logic [7:0]  dbyte;
		logic        dvalid;
		logic [12:0] len;
		logic        lastr;
	} response_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  func;
	logic [15:0] key;
	logic [10:0] occurrence;
	logic [12:0] value_length;
	logic [7:0]  value_byte;
	logic        last_byte;
	logic [6:0]  read_limit;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  status;
	logic [7:0]  data_byte;
	logic        data_valid;
	logic [12:0] stored_length;
	logic        last_result;

	packed_key_value_record_store u_top (.*);

	// store shadow state
	logic [7:0] shadow_mem [STORE_BYTES];
	int unsigned used_cnt;
	int unsigned wr_ptr;
	bit set_open;
	bit set_fits;

	request_t  pending_reqs[$];
	response_t expected_rsps[$];
	request_t  cur_req;
	int        err_count;
	int        req_gap;
	int        rsp_gap;
	int        stall_cycles;
	bit        quiet;
	logic [15:0] key_pool[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned rd8(int unsigned a);
		return a < STORE_BYTES ? int'(shadow_mem[a]) : 0;
	endfunction

	function automatic int unsigned rd16(int unsigned a);
		return rd8(a) | (rd8(a + 1) << 8);
	endfunction

	task automatic wr8(int unsigned a, int unsigned v);
		if (a < STORE_BYTES) shadow_mem[a] = v[7:0];
	endtask

	task automatic wr16(int unsigned a, int unsigned v);
		wr8(a, v);
		wr8(a + 1, v >> 8);
	endtask

	// record size at pos, clipped to the occupied area
	function automatic int unsigned rec_size(int unsigned pos);
		int unsigned blk;
		blk = pkvrs_pkg::HDR_BYTES + rd16(pos + 2);
		if (blk > used_cnt - pos) blk = used_cnt - pos;
		return blk;
	endfunction

	task automatic drop_record(int unsigned pos, int unsigned blk);
		int unsigned nxt;
		nxt = pos + blk;
		if (nxt < used_cnt && nxt <= STORE_BYTES)
			for (int unsigned i = 0; i < used_cnt - nxt; i++)
				shadow_mem[pos + i] = shadow_mem[nxt + i];
		used_cnt -= blk;
	endtask

	function automatic bit find_record(int unsigned k, int unsigned occ,
			output int unsigned at);
		int unsigned i;
		int unsigned cnt;
		i = 0;
		cnt = 0;
		at = 0;
		while (i + pkvrs_pkg::HDR_BYTES <= used_cnt) begin
			if (rd16(i) == k) begin
				if (cnt == occ) begin
					at = i;
					return 1'b1;
				end
				cnt++;
			end
			i += rec_size(i);
		end
		return 1'b0;
	endfunction

	task automatic push_rsp(pkvrs_pkg::status_t st, int unsigned b, bit v,
			int unsigned len, bit l);
		response_t r;
		r.st = st;
		r.dbyte = b[7:0];
		r.dvalid = v;
		r.len = len[12:0];
		r.lastr = l;
		expected_rsps.push_back(r);
	endtask

	// expected responses for one accepted request
	task automatic predict_store(request_t q);
		int unsigned pos;
		int unsigned i;
		int unsigned blk;
		int unsigned len;
		int unsigned n;
		int unsigned got;
		if (q.op == pkvrs_pkg::FUNC_NOP) return;
		if (q.op == pkvrs_pkg::FUNC_SET) begin
			if (!set_open) begin
				i = 0;
				while (i + pkvrs_pkg::HDR_BYTES <= used_cnt) begin
					blk = rec_size(i);
					if (rd16(i) == q.key) drop_record(i, blk);
					else i += blk;
				end
				set_open = 1'b1;
				if (used_cnt + pkvrs_pkg::HDR_BYTES + q.vlen <= STORE_BYTES) begin
					wr16(used_cnt, q.key);
					wr16(used_cnt + 2, q.vlen);
					wr_ptr = used_cnt + pkvrs_pkg::HDR_BYTES;
					set_fits = 1'b1;
				end else begin
					wr_ptr = used_cnt;
					set_fits = 1'b0;
				end
			end
			if (set_fits &&
					(wr_ptr - (used_cnt + pkvrs_pkg::HDR_BYTES)) < rd16(used_cnt + 2)) begin
				wr8(wr_ptr, q.vbyte);
				wr_ptr++;
			end
			if (!q.lastb) return;
			set_open = 1'b0;
			if (set_fits) begin
				got = wr_ptr - (used_cnt + pkvrs_pkg::HDR_BYTES);
				wr16(used_cnt + 2, got);
				used_cnt = wr_ptr;
				set_fits = 1'b0;
				push_rsp(pkvrs_pkg::STAT_OK, 0, 1'b0, got, 1'b1);
			end else
				push_rsp(pkvrs_pkg::STAT_NOSPC, 0, 1'b0, 0, 1'b1);
			return;
		end
		// get or delete cancels an open set
		set_open = 1'b0;
		set_fits = 1'b0;
		wr_ptr = used_cnt;
		if (!find_record(q.key, q.occ, pos)) begin
			push_rsp(pkvrs_pkg::STAT_NOTFND, 0, 1'b0, 0, 1'b1);
			return;
		end
		len = rd16(pos + 2);
		if (q.op == pkvrs_pkg::FUNC_DEL) begin
			drop_record(pos, rec_size(pos));
			wr_ptr = used_cnt;
			push_rsp(pkvrs_pkg::STAT_OK, 0, 1'b0, len, 1'b1);
			return;
		end
		n = q.limit;
		if (n > READ_MAX) n = READ_MAX;
		if (n > len) n = len;
		if (n == 0)
			push_rsp(pkvrs_pkg::STAT_OK, 0, 1'b0, len, 1'b1);
		for (int unsigned k = 0; k < n; k++)
			push_rsp(pkvrs_pkg::STAT_OK, rd8(pos + pkvrs_pkg::HDR_BYTES + k), 1'b1, len,
				k + 1 == n);
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		err_count++;
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	function automatic request_t rand_req(pkvrs_pkg::func_t op);
		request_t q;
		q.op = op;
		q.key = $urandom_range(0, 3) == 0 ? 16'($urandom) : key_pool[$urandom_range(0, 3)];
		q.occ = $urandom_range(0, 7) == 0 ? 11'($urandom) : 11'($urandom_range(0, 2));
		q.vlen = 13'($urandom);
		q.vbyte = 8'($urandom);
		q.lastb = 1'($urandom);
		q.limit = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 20));
		return q;
	endfunction

	// set stream: first item carries key and length, later ones random there
	task automatic queue_set(logic [15:0] k, logic [12:0] vlen, int unsigned nbytes);
		request_t q;
		for (int unsigned i = 0; i < (nbytes == 0 ? 1 : nbytes); i++) begin
			q = rand_req(pkvrs_pkg::FUNC_SET);
			if (i == 0) begin
				q.key = k;
				q.vlen = vlen;
			end
			q.lastb = (i + 1 >= nbytes);
			pending_reqs.push_back(q);
		end
	endtask

	task automatic queue_op(pkvrs_pkg::func_t op, logic [15:0] k, logic [10:0] occ,
			logic [6:0] lim);
		request_t q;
		q = rand_req(op);
		q.key = k;
		q.occ = occ;
		q.limit = lim;
		pending_reqs.push_back(q);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			func <= '0;
			key <= '0;
			occurrence <= '0;
			value_length <= '0;
			value_byte <= '0;
			last_byte <= 1'b0;
			read_limit <= '0;
			req_gap = 0;
		end else begin
			if (req_valid && req_ready) predict_store(cur_req);
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					req_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					req_gap = $urandom_range(0, 4);
					req_valid <= 1'b0;
				end else begin
					cur_req = pending_reqs.pop_front();
					func <= cur_req.op;
					key <= cur_req.key;
					occurrence <= cur_req.occ;
					value_length <= cur_req.vlen;
					value_byte <= cur_req.vbyte;
					last_byte <= cur_req.lastb;
					read_limit <= cur_req.limit;
					req_valid <= 1'b1;
				end
			end
		end
	end

	// response monitor and ready pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0)
					report_mismatch("unexpected transfer, count", 1, 0);
				else begin
					response_t e;
					e = expected_rsps.pop_front();
					if (status !== e.st) report_mismatch("status", status, e.st);
					if (data_byte !== e.dbyte) report_mismatch("data_byte", data_byte, e.dbyte);
					if (data_valid !== e.dvalid)
						report_mismatch("data_valid", data_valid, e.dvalid);
					if (stored_length !== e.len)
						report_mismatch("stored_length", stored_length, e.len);
					if (last_result !== e.lastr)
						report_mismatch("last_result", last_result, e.lastr);
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_gap = $urandom_range(0, 4);
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("** packed_key_value_record_store: FAILED **");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		int unsigned r;
		int unsigned vlen;
		int unsigned nb;
		used_cnt = 0;
		wr_ptr = 0;
		set_open = 1'b0;
		set_fits = 1'b0;
		err_count = 0;
		stall_cycles = 0;
		quiet = 1'b0;
		arst_n = 1'b0;

		// directed: extremes, every operation, the special cases
		queue_op(pkvrs_pkg::FUNC_GET, 16'h1234, 11'd0, 7'd10);    // miss on empty store
		queue_op(pkvrs_pkg::FUNC_DEL, 16'hFFFF, 11'h7FF, 7'd0);   // delete miss
		queue_set(16'hFFFF, 13'd8188, 2);                         // exact fit, short stream
		queue_set(16'h0000, 13'd1, 1);                            // single-byte stream
		queue_op(pkvrs_pkg::FUNC_GET, 16'hFFFF, 11'd0, 7'd127);   // limit above max
		queue_op(pkvrs_pkg::FUNC_DEL, 16'hFFFF, 11'd0, 7'd0);
		queue_set(16'h0000, 13'd0, 0);                            // zero length
		queue_op(pkvrs_pkg::FUNC_GET, 16'h0000, 11'd0, 7'd5);     // empty record
		queue_set(16'h1234, 13'd3, 5);                            // long stream
		queue_op(pkvrs_pkg::FUNC_GET, 16'h1234, 11'd0, 7'd64);
		queue_op(pkvrs_pkg::FUNC_GET, 16'h1234, 11'd0, 7'd0);     // length only
		queue_set(16'h1234, 13'd4, 2);                            // short stream
		queue_op(pkvrs_pkg::FUNC_GET, 16'h1234, 11'd0, 7'd4);
		queue_op(pkvrs_pkg::FUNC_NOP, 16'h0000, 11'd0, 7'd0);
		queue_set(16'hA5A5, 13'd8191, 1);                         // oversize
		queue_set(16'hA5A5, 13'd2, 2);
		queue_op(pkvrs_pkg::FUNC_GET, 16'hA5A5, 11'd1, 7'd2);     // occurrence miss
		queue_op(pkvrs_pkg::FUNC_GET, 16'hA5A5, 11'd0, 7'd1);

		// random: mostly well-formed set streams, gets and deletes
		while (pending_reqs.size() < 100) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				vlen = $urandom_range(0, 6) == 0 ? $urandom_range(0, 8191) : $urandom_range(0, 12);
				nb = vlen > 12 ? $urandom_range(1, 3) : vlen;
				if ($urandom_range(0, 4) == 0) nb = $urandom_range(0, 14);
				queue_set(key_pool[$urandom_range(0, 3)], vlen[12:0], nb);
			end else if (r < 53) begin
				queue_set(key_pool[$urandom_range(0, 3)], 13'($urandom_range(2, 10)), 0);
				pending_reqs[pending_reqs.size() - 1].lastb = 1'b0;
				pending_reqs.push_back(rand_req($urandom_range(0, 1) ? pkvrs_pkg::FUNC_GET
				                                                     : pkvrs_pkg::FUNC_DEL));
			end else if (r < 78)
				pending_reqs.push_back(rand_req(pkvrs_pkg::FUNC_GET));
			else if (r < 94)
				pending_reqs.push_back(rand_req(pkvrs_pkg::FUNC_DEL));
			else
				pending_reqs.push_back(rand_req(pkvrs_pkg::FUNC_NOP));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// no idling over the tail of the run
		while (pending_reqs.size() > 25) @(posedge clk);
		quiet = 1'b1;
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (rsp_valid) report_mismatch("unexpected trailing transfer, count", 1, 0);
		if (err_count == 0)
			$display("** packed_key_value_record_store: PASSED **");
		else
			$display("** packed_key_value_record_store: FAILED **");
		$finish;
	end
endmodule
